### src/pl0s_pkg.sv
// ----------------------------------------------------------------------------
// pl0s_pkg: shared types and constants of the PL/0 token scanner
// Token codes, status codes and the record passed from front to back.
// ----------------------------------------------------------------------------
package pl0s_pkg;

  localparam logic [5:0] TK_NONE    = 6'd0;
  localparam logic [5:0] TK_IDENT   = 6'd2;
  localparam logic [5:0] TK_NUMBER  = 6'd3;
  localparam logic [5:0] TK_PLUS    = 6'd4;
  localparam logic [5:0] TK_MINUS   = 6'd5;
  localparam logic [5:0] TK_TIMES   = 6'd6;
  localparam logic [5:0] TK_SLASH   = 6'd7;
  localparam logic [5:0] TK_EQL     = 6'd9;
  localparam logic [5:0] TK_NEQ     = 6'd10;
  localparam logic [5:0] TK_LSS     = 6'd11;
  localparam logic [5:0] TK_LEQ     = 6'd12;
  localparam logic [5:0] TK_GTR     = 6'd13;
  localparam logic [5:0] TK_GEQ     = 6'd14;
  localparam logic [5:0] TK_LPAREN  = 6'd15;
  localparam logic [5:0] TK_RPAREN  = 6'd16;
  localparam logic [5:0] TK_COMMA   = 6'd17;
  localparam logic [5:0] TK_SEMI    = 6'd18;
  localparam logic [5:0] TK_PERIOD  = 6'd19;
  localparam logic [5:0] TK_BECOMES = 6'd20;
  localparam logic [5:0] TK_BEGIN   = 6'd21;
  localparam logic [5:0] TK_END     = 6'd22;
  localparam logic [5:0] TK_IF      = 6'd23;
  localparam logic [5:0] TK_THEN    = 6'd24;
  localparam logic [5:0] TK_WHILE   = 6'd25;
  localparam logic [5:0] TK_DO      = 6'd26;
  localparam logic [5:0] TK_CALL    = 6'd27;
  localparam logic [5:0] TK_CONST   = 6'd28;
  localparam logic [5:0] TK_VAR     = 6'd29;
  localparam logic [5:0] TK_PROC    = 6'd30;
  localparam logic [5:0] TK_WRITE   = 6'd31;
  localparam logic [5:0] TK_READ    = 6'd32;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NUM_LONG = 2'd1;
  localparam logic [1:0] ST_NAME_LONG = 2'd2;
  localparam logic [1:0] ST_BAD_SYM  = 2'd3;

  localparam int NAME_BYTES = 11;

  // One result beat.
  typedef struct packed {
    logic [5:0]  token_code;
    logic [16:0] number_value;
    logic [63:0] name_first;
    logic [23:0] name_rest;
    logic [3:0]  name_length;
    logic [1:0]  status;
    logic        run_last;
  } tok_t;

  // Record handed from the front end to the back end: up to two beats.
  // A name token is still raw here; the back end does the keyword lookup.
  typedef struct packed {
    logic  first_vld;
    tok_t  first;
    logic  second_vld;
    tok_t  second;
  } job_t;

  function automatic logic [5:0] keyword_code(input logic [87:0] nm,
                                              input logic [3:0] len);
    logic [5:0] code;
    code = TK_IDENT;
    unique case (len)
      4'd2: begin
        if (nm[15:0] == "fi") code = TK_IF;
        else if (nm[15:0] == "od") code = TK_DO;
      end
      4'd3: begin
        if (nm[23:0] == "rav") code = TK_VAR;
        else if (nm[23:0] == "dne") code = TK_END;
      end
      4'd4: begin
        if (nm[31:0] == "neht") code = TK_THEN;
        else if (nm[31:0] == "daer") code = TK_READ;
        else if (nm[31:0] == "llac") code = TK_CALL;
      end
      4'd5: begin
        if (nm[39:0] == "tsnoc") code = TK_CONST;
        else if (nm[39:0] == "nigeb") code = TK_BEGIN;
        else if (nm[39:0] == "elihw") code = TK_WHILE;
        else if (nm[39:0] == "etirw") code = TK_WRITE;
      end
      4'd9: begin
        if (nm[71:0] == "erudecorp") code = TK_PROC;
      end
      default: code = TK_IDENT;
    endcase
    return code;
  endfunction

endpackage

### src/pl0s_if.sv
// ----------------------------------------------------------------------------
// pl0s_in_if / pl0s_out_if: valid/ready channels of the token scanner
// Input carries one source byte, output carries one token beat.
// ----------------------------------------------------------------------------
interface pl0s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_text;
  modport source (output valid, character, end_of_text, input ready);
  modport sink (input valid, character, end_of_text, output ready);
endinterface

interface pl0s_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_code;
  logic [16:0] number_value;
  logic [63:0] name_first;
  logic [23:0] name_rest;
  logic [3:0]  name_length;
  logic [1:0]  status;
  logic        run_last;
  modport source (output valid, token_code, number_value, name_first, name_rest,
                  name_length, status, run_last, input ready);
  modport sink (input valid, token_code, number_value, name_first, name_rest,
                name_length, status, run_last, output ready);
endinterface

### src/pl0s_front.sv
// ----------------------------------------------------------------------------
// pl0s_front: character classifier and scanner state machine
// Consumes one byte per beat and produces a job of zero to two raw tokens.
// ----------------------------------------------------------------------------
module pl0s_front #(
  parameter int MaxNameChars = 11,
  parameter int MaxDigits    = 5
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_character,
  input  logic            in_end_of_text,
  output logic            job_valid,
  input  logic            job_ready,
  output pl0s_pkg::job_t  job
);

  // The counter serves both names and numbers, so it must hold the larger limit.
  localparam int CntMax = (MaxNameChars > MaxDigits) ? MaxNameChars : MaxDigits;
  localparam int CW = $clog2(CntMax + 1);

  localparam logic [3:0] M_IDLE = 4'd0, M_IDENT = 4'd1, M_NUMBER = 4'd2,
    M_LESS = 4'd3, M_GREATER = 4'd4, M_COLON = 4'd5, M_SLASH = 4'd6,
    M_COMMENT = 4'd7, M_CSTAR = 4'd8, M_HALTED = 4'd9;

  logic [3:0]    mode_r, mode_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [16:0]   acc_r, acc_nxt;
  logic [7:0]    name_r [pl0s_pkg::NAME_BYTES];
  logic          wr_en;

  logic [7:0] c;
  logic is_letter, is_digit, is_space, go;
  logic [16:0] acc_x10;
  logic [3:0] dig;

  pl0s_pkg::tok_t pend_tok, idle_tok;
  logic pend_vld, idle_vld;
  logic [3:0] idle_mode;
  logic [87:0] name_flat;

  assign c = in_character;
  assign is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  assign is_digit  = c >= "0" && c <= "9";
  assign is_space  = c == " " || (c >= 8'd9 && c <= 8'd13);
  assign dig = 4'(c - "0");
  assign acc_x10 = (acc_r << 3) + (acc_r << 1);
  assign in_ready = job_ready;
  assign go = in_valid && in_ready;

  function automatic pl0s_pkg::tok_t mk(input logic [5:0] code, input logic [1:0] st);
    pl0s_pkg::tok_t t;
    t = '0;
    t.token_code = code;
    t.status = st;
    return t;
  endfunction

  always_comb begin
    for (int i = 0; i < pl0s_pkg::NAME_BYTES; i++) begin
      name_flat[8*i +: 8] = (i < int'(cnt_r) && i < MaxNameChars) ? name_r[i] : 8'd0;
    end
  end

  // What a byte does when scanned from idle.
  always_comb begin
    idle_vld = 1'b0;
    idle_tok = '0;
    idle_mode = M_IDLE;
    if (is_space) begin
      idle_mode = M_IDLE;
    end else if (is_letter) begin
      idle_mode = M_IDENT;
    end else if (is_digit) begin
      idle_mode = M_NUMBER;
    end else begin
      idle_vld = 1'b1;
      unique case (c)
        "<": begin idle_vld = 1'b0; idle_mode = M_LESS; end
        ">": begin idle_vld = 1'b0; idle_mode = M_GREATER; end
        ":": begin idle_vld = 1'b0; idle_mode = M_COLON; end
        "/": begin idle_vld = 1'b0; idle_mode = M_SLASH; end
        "+": idle_tok = mk(pl0s_pkg::TK_PLUS, pl0s_pkg::ST_OK);
        "-": idle_tok = mk(pl0s_pkg::TK_MINUS, pl0s_pkg::ST_OK);
        "*": idle_tok = mk(pl0s_pkg::TK_TIMES, pl0s_pkg::ST_OK);
        "=": idle_tok = mk(pl0s_pkg::TK_EQL, pl0s_pkg::ST_OK);
        "(": idle_tok = mk(pl0s_pkg::TK_LPAREN, pl0s_pkg::ST_OK);
        ")": idle_tok = mk(pl0s_pkg::TK_RPAREN, pl0s_pkg::ST_OK);
        ",": idle_tok = mk(pl0s_pkg::TK_COMMA, pl0s_pkg::ST_OK);
        ";": idle_tok = mk(pl0s_pkg::TK_SEMI, pl0s_pkg::ST_OK);
        ".": idle_tok = mk(pl0s_pkg::TK_PERIOD, pl0s_pkg::ST_OK);
        default: begin
          idle_tok = mk(pl0s_pkg::TK_NONE, pl0s_pkg::ST_BAD_SYM);
          idle_mode = M_HALTED;
        end
      endcase
    end
  end

  // Token pending in the current mode, emitted when it is closed.
  always_comb begin
    pend_tok = '0;
    pend_vld = 1'b1;
    unique case (mode_r)
      M_IDENT: begin
        pend_tok.token_code = pl0s_pkg::TK_IDENT;
        pend_tok.name_first = name_flat[63:0];
        pend_tok.name_rest = name_flat[87:64];
        pend_tok.name_length = 4'(cnt_r);
      end
      M_NUMBER: begin
        pend_tok.token_code = pl0s_pkg::TK_NUMBER;
        pend_tok.number_value = acc_r;
      end
      M_LESS: pend_tok.token_code = pl0s_pkg::TK_LSS;
      M_GREATER: pend_tok.token_code = pl0s_pkg::TK_GTR;
      M_SLASH: pend_tok.token_code = pl0s_pkg::TK_SLASH;
      M_COLON: pend_tok = mk(pl0s_pkg::TK_NONE, pl0s_pkg::ST_BAD_SYM);
      default: pend_vld = 1'b0;
    endcase
  end

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    wr_en = 1'b0;
    job = '0;
    if (mode_r == M_HALTED) begin
      mode_nxt = M_HALTED;
    end else if (in_end_of_text) begin
      job.first_vld = pend_vld;
      job.first = pend_tok;
      mode_nxt = (mode_r == M_COLON) ? M_HALTED : M_IDLE;
    end else begin
      priority if ((mode_r == M_IDENT && (is_letter || is_digit)) ||
                   (mode_r == M_NUMBER && is_digit)) begin
        if (mode_r == M_IDENT && int'(cnt_r) >= MaxNameChars) begin
          job.first_vld = 1'b1;
          job.first = mk(pl0s_pkg::TK_NONE, pl0s_pkg::ST_NAME_LONG);
          mode_nxt = M_HALTED;
        end else if (mode_r == M_NUMBER && int'(cnt_r) >= MaxDigits) begin
          job.first_vld = 1'b1;
          job.first = mk(pl0s_pkg::TK_NONE, pl0s_pkg::ST_NUM_LONG);
          mode_nxt = M_HALTED;
        end else begin
          wr_en = (mode_r == M_IDENT);
          acc_nxt = acc_x10 + 17'(dig);
          cnt_nxt = cnt_r + 1'b1;
        end
      end else if ((mode_r == M_LESS || mode_r == M_GREATER || mode_r == M_COLON)
                   && c == "=") begin
        job.first_vld = 1'b1;
        job.first = mk(mode_r == M_LESS ? pl0s_pkg::TK_LEQ :
                       mode_r == M_GREATER ? pl0s_pkg::TK_GEQ : pl0s_pkg::TK_BECOMES,
                       pl0s_pkg::ST_OK);
        mode_nxt = M_IDLE;
      end else if (mode_r == M_LESS && c == ">") begin
        job.first_vld = 1'b1;
        job.first = mk(pl0s_pkg::TK_NEQ, pl0s_pkg::ST_OK);
        mode_nxt = M_IDLE;
      end else if (mode_r == M_COLON) begin
        job.first_vld = 1'b1;
        job.first = pend_tok;
        mode_nxt = M_HALTED;
      end else if (mode_r == M_SLASH && c == "*") begin
        mode_nxt = M_COMMENT;
      end else if (mode_r == M_COMMENT) begin
        if (c == "*") mode_nxt = M_CSTAR;
      end else if (mode_r == M_CSTAR) begin
        if (c == "/") mode_nxt = M_IDLE;
        else if (c != "*") mode_nxt = M_COMMENT;
      end else begin
        // Close any pending token, then scan the byte from idle.
        job.first_vld = pend_vld;
        job.first = pend_tok;
        job.second_vld = idle_vld;
        job.second = idle_tok;
        mode_nxt = idle_mode;
        if (is_letter || is_digit) begin
          cnt_nxt = CW'(1);
          acc_nxt = 17'(dig);
          wr_en = is_letter;
        end
      end
    end
    // Compact so that a lone beat sits in the first slot.
    if (!job.first_vld && job.second_vld) begin
      job.first_vld = 1'b1;
      job.first = job.second;
      job.second_vld = 1'b0;
    end
    if (job.second_vld) job.second.run_last = 1'b1;
    else job.first.run_last = 1'b1;
  end

  assign job_valid = go && job.first_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      cnt_r <= '0;
      acc_r <= '0;
    end else if (go) begin
      mode_r <= mode_nxt;
      cnt_r <= cnt_nxt;
      acc_r <= acc_nxt;
    end
  end

  // Name store: written at the next free place; a write past the end is dropped.
  always_ff @(posedge clk) begin
    if (go && wr_en) begin
      for (int i = 0; i < pl0s_pkg::NAME_BYTES; i++) begin
        if ((mode_r == M_IDENT) ? (int'(cnt_r) == i) : (i == 0)) name_r[i] <= c;
      end
    end
  end

endmodule

### src/pl0s_queue.sv
// ----------------------------------------------------------------------------
// pl0s_queue: two-entry job queue between front and back
// Full throughput with registered outputs on both sides.
// ----------------------------------------------------------------------------
module pl0s_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  pl0s_pkg::job_t wr_job,
  output logic           rd_valid,
  input  logic           rd_ready,
  output pl0s_pkg::job_t rd_job
);

  pl0s_pkg::job_t mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_job = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_job;
  end

endmodule

### src/pl0s_back.sv
// ----------------------------------------------------------------------------
// pl0s_back: keyword lookup and beat serializer
// Resolves reserved words and sends the one or two beats of each job.
// ----------------------------------------------------------------------------
module pl0s_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  output logic           job_ready,
  input  pl0s_pkg::job_t job,
  output logic           out_valid,
  input  logic           out_ready,
  output pl0s_pkg::tok_t out_tok
);

  logic           valid_r;
  pl0s_pkg::tok_t tok_r;
  logic           sel_r;
  logic           take, last_of_job;
  pl0s_pkg::tok_t raw, res;

  assign raw = sel_r ? job.second : job.first;
  assign last_of_job = sel_r || !job.second_vld;
  assign take = job_valid && (!valid_r || out_ready);
  assign job_ready = take && last_of_job;

  always_comb begin
    res = raw;
    if (raw.token_code == pl0s_pkg::TK_IDENT) begin
      res.token_code = pl0s_pkg::keyword_code({raw.name_rest, raw.name_first},
                                              raw.name_length);
      if (res.token_code != pl0s_pkg::TK_IDENT) begin
        res.name_first = '0;
        res.name_rest = '0;
        res.name_length = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r <= 1'b0;
    end else begin
      if (take) sel_r <= !last_of_job;
      if (take) valid_r <= 1'b1;
      else if (out_ready) valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) tok_r <= res;
  end

  assign out_valid = valid_r;
  assign out_tok = tok_r;

endmodule

### src/pl0_token_scanner.sv
// Path: a token is held in the job queue, then in the back end output register.
// Throughput: one byte per cycle while the job queue has room; a byte that yields
// two tokens sends them in turn through the back end's single output register.
// Reset: synchronous, active low; the scanner returns to idle, clears its counters
// and queue, and leaves a halt after an error.
// ----------------------------------------------------------------------------
// pl0_token_scanner: PL/0 lexical scanner
// Turns a stream of source bytes into PL/0 tokens, one beat per token.
// ----------------------------------------------------------------------------
// The front end tracks the scan mode, the name characters and the digit count,
// and closes tokens when a delimiter arrives. Each accepted byte makes a job of
// zero, one or two raw tokens; jobs go through a two-entry queue so that the
// front keeps taking bytes while the output is stalled, until the queue is full.
// The back end looks up reserved words and sends the beats of each job in order,
// marking the last beat of a byte with run_last. After any error beat the front
// halts and drops every later byte until reset.
module pl0_token_scanner #(
  parameter int MaxNameChars = 11,
  parameter int MaxDigits    = 5
) (
  input logic        clk,
  input logic        rst_n,
  pl0s_in_if.sink    in_ch,
  pl0s_out_if.source out_ch
);

  logic           fj_valid, fj_ready, bj_valid, bj_ready;
  pl0s_pkg::job_t fj, bj;
  pl0s_pkg::tok_t tok;

  pl0s_front #(.MaxNameChars(MaxNameChars), .MaxDigits(MaxDigits)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_character(in_ch.character), .in_end_of_text(in_ch.end_of_text),
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  pl0s_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_job(bj)
  );

  pl0s_back u_back (
    .clk(clk), .rst_n(rst_n),
    .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_tok(tok)
  );

  assign out_ch.token_code   = tok.token_code;
  assign out_ch.number_value = tok.number_value;
  assign out_ch.name_first   = tok.name_first;
  assign out_ch.name_rest    = tok.name_rest;
  assign out_ch.name_length  = tok.name_length;
  assign out_ch.status       = tok.status;
  assign out_ch.run_last     = tok.run_last;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the PL/0 token scanner
// Source text is fed one byte per beat. A model of the scanner predicts
// every token beat, and the monitor checks each one in order.
// ----------------------------------------------------------------------------
module testbench;

  // Scan states of the prediction model.
  typedef enum logic [3:0] {
    SM_IDLE, SM_IDENT, SM_NUMBER, SM_LESS, SM_GREATER, SM_COLON,
    SM_SLASH, SM_COMMENT, SM_CSTAR, SM_HALTED
  } scan_mode_t;

  typedef struct {
    logic [7:0] ch;
    logic       eot;
  } src_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pl0s_in_if  in_ch ();
  pl0s_out_if out_ch ();

  pl0_token_scanner u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Bytes waiting to be sent, tokens waiting to arrive, and the tokens that
  // the byte now being predicted produces.
  src_beat_t       text_q[$];
  pl0s_pkg::tok_t  token_q[$];
  pl0s_pkg::tok_t  byte_toks[$];

  // Model state.
  scan_mode_t  mode;
  logic [7:0]  name_buf[11];
  int unsigned char_cnt;
  logic [16:0] num_acc;

  int  beats_sent = 0;
  int  toks_seen = 0;
  int  fail_cnt = 0;
  int  cycle_cnt = 0;
  bit  took = 1'b0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  err_kind;

  string reserved[12] = '{"var", "const", "begin", "end", "if", "then", "while",
                          "do", "read", "write", "procedure", "call"};
  string symbols[17] = '{"+", "-", "*", "=", "(", ")", ",", ";", ".", "<", "<=",
                         "<>", ">", ">=", ":=", "/", "<"};

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic pl0s_pkg::tok_t make_tok(logic [5:0] code, logic [16:0] value,
                                              logic [63:0] first, logic [23:0] rest,
                                              logic [3:0] len, logic [1:0] st);
    pl0s_pkg::tok_t t;
    t.token_code   = code;
    t.number_value = value;
    t.name_first   = first;
    t.name_rest    = rest;
    t.name_length  = len;
    t.status       = st;
    t.run_last     = 1'b0;
    return t;
  endfunction

  task automatic add_sym(logic [5:0] code);
    byte_toks.push_back(make_tok(code, '0, '0, '0, '0, pl0s_pkg::ST_OK));
  endtask

  task automatic add_error(logic [1:0] st);
    byte_toks.push_back(make_tok(pl0s_pkg::TK_NONE, '0, '0, '0, '0, st));
    mode = SM_HALTED;
  endtask

  // A finished name is either a reserved word (no name fields) or an
  // identifier with its characters packed low byte first.
  task automatic close_name();
    string       s;
    logic [5:0]  code;
    logic [63:0] first;
    logic [23:0] rest;
    s = "";
    first = '0;
    rest = '0;
    for (int i = 0; i < char_cnt; i++) begin
      s = $sformatf("%s%c", s, name_buf[i]);
      if (i < 8) first[8*i +: 8] = name_buf[i];
      else rest[8*(i-8) +: 8] = name_buf[i];
    end
    case (s)
      "begin":     code = pl0s_pkg::TK_BEGIN;
      "end":       code = pl0s_pkg::TK_END;
      "if":        code = pl0s_pkg::TK_IF;
      "then":      code = pl0s_pkg::TK_THEN;
      "while":     code = pl0s_pkg::TK_WHILE;
      "do":        code = pl0s_pkg::TK_DO;
      "call":      code = pl0s_pkg::TK_CALL;
      "const":     code = pl0s_pkg::TK_CONST;
      "var":       code = pl0s_pkg::TK_VAR;
      "procedure": code = pl0s_pkg::TK_PROC;
      "write":     code = pl0s_pkg::TK_WRITE;
      "read":      code = pl0s_pkg::TK_READ;
      default:     code = pl0s_pkg::TK_IDENT;
    endcase
    if (code != pl0s_pkg::TK_IDENT) add_sym(code);
    else byte_toks.push_back(make_tok(pl0s_pkg::TK_IDENT, '0, first, rest, char_cnt[3:0],
                                      pl0s_pkg::ST_OK));
  endtask

  // A byte seen with no token open.
  task automatic begin_token(logic [7:0] c);
    mode = SM_IDLE;
    if (is_blank(c)) return;
    if (is_letter(c)) begin
      name_buf[0] = c;
      char_cnt = 1;
      mode = SM_IDENT;
      return;
    end
    if (is_digit(c)) begin
      num_acc = 17'(c - "0");
      char_cnt = 1;
      mode = SM_NUMBER;
      return;
    end
    case (c)
      "<": mode = SM_LESS;
      ">": mode = SM_GREATER;
      ":": mode = SM_COLON;
      "/": mode = SM_SLASH;
      "+": add_sym(pl0s_pkg::TK_PLUS);
      "-": add_sym(pl0s_pkg::TK_MINUS);
      "*": add_sym(pl0s_pkg::TK_TIMES);
      "=": add_sym(pl0s_pkg::TK_EQL);
      "(": add_sym(pl0s_pkg::TK_LPAREN);
      ")": add_sym(pl0s_pkg::TK_RPAREN);
      ",": add_sym(pl0s_pkg::TK_COMMA);
      ";": add_sym(pl0s_pkg::TK_SEMI);
      ".": add_sym(pl0s_pkg::TK_PERIOD);
      default: add_error(pl0s_pkg::ST_BAD_SYM);
    endcase
  endtask

  // Works out the token beats that one accepted byte causes and queues them.
  task automatic predict_beat(logic [7:0] c, logic eot);
    byte_toks.delete();
    if (mode == SM_HALTED) return;
    if (eot) begin
      case (mode)
        SM_IDENT:   close_name();
        SM_NUMBER:  byte_toks.push_back(make_tok(pl0s_pkg::TK_NUMBER, num_acc, '0, '0, '0,
                                                 pl0s_pkg::ST_OK));
        SM_LESS:    add_sym(pl0s_pkg::TK_LSS);
        SM_GREATER: add_sym(pl0s_pkg::TK_GTR);
        SM_SLASH:   add_sym(pl0s_pkg::TK_SLASH);
        SM_COLON:   add_error(pl0s_pkg::ST_BAD_SYM);
        default: ;
      endcase
      if (mode != SM_HALTED) mode = SM_IDLE;
    end else begin
      case (mode)
        SM_IDENT: begin
          if (is_letter(c) || is_digit(c)) begin
            if (char_cnt >= pl0s_pkg::NAME_BYTES) add_error(pl0s_pkg::ST_NAME_LONG);
            else begin
              name_buf[char_cnt] = c;
              char_cnt++;
            end
          end else begin
            close_name();
            begin_token(c);
          end
        end
        SM_NUMBER: begin
          if (is_digit(c)) begin
            if (char_cnt >= 5) add_error(pl0s_pkg::ST_NUM_LONG);
            else begin
              num_acc = 17'(num_acc * 10 + (c - "0"));
              char_cnt++;
            end
          end else begin
            byte_toks.push_back(make_tok(pl0s_pkg::TK_NUMBER, num_acc, '0, '0, '0,
                                         pl0s_pkg::ST_OK));
            begin_token(c);
          end
        end
        SM_LESS: begin
          if (c == "=") begin
            add_sym(pl0s_pkg::TK_LEQ);
            mode = SM_IDLE;
          end else if (c == ">") begin
            add_sym(pl0s_pkg::TK_NEQ);
            mode = SM_IDLE;
          end else begin
            add_sym(pl0s_pkg::TK_LSS);
            begin_token(c);
          end
        end
        SM_GREATER: begin
          if (c == "=") begin
            add_sym(pl0s_pkg::TK_GEQ);
            mode = SM_IDLE;
          end else begin
            add_sym(pl0s_pkg::TK_GTR);
            begin_token(c);
          end
        end
        SM_COLON: begin
          if (c == "=") begin
            add_sym(pl0s_pkg::TK_BECOMES);
            mode = SM_IDLE;
          end else add_error(pl0s_pkg::ST_BAD_SYM);
        end
        SM_SLASH: begin
          if (c == "*") mode = SM_COMMENT;
          else begin
            add_sym(pl0s_pkg::TK_SLASH);
            begin_token(c);
          end
        end
        SM_COMMENT: if (c == "*") mode = SM_CSTAR;
        SM_CSTAR: begin
          if (c == "/") mode = SM_IDLE;
          else if (c != "*") mode = SM_COMMENT;
        end
        default: begin_token(c);
      endcase
    end
    if (byte_toks.size() > 0) byte_toks[byte_toks.size()-1].run_last = 1'b1;
    foreach (byte_toks[i]) token_q.push_back(byte_toks[i]);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic push_text(string s);
    src_beat_t b;
    for (int i = 0; i < s.len(); i++) begin
      b.ch = s[i];
      b.eot = 1'b0;
      text_q.push_back(b);
    end
  endtask

  // The character lane is don't-care on an end marker, so it carries noise.
  task automatic push_eot();
    src_beat_t b;
    b.ch = 8'($urandom_range(0, 255));
    b.eot = 1'b1;
    text_q.push_back(b);
  endtask

  function automatic string rand_alnum(bit letter_only);
    int r;
    r = letter_only ? $urandom_range(0, 51) : $urandom_range(0, 61);
    if (r < 26) return $sformatf("%c", 8'("a" + r));
    if (r < 52) return $sformatf("%c", 8'("A" + r - 26));
    return $sformatf("%c", 8'("0" + r - 52));
  endfunction

  function automatic string blank_run();
    string s;
    int    c;
    s = "";
    repeat ($urandom_range(1, 2)) begin
      c = $urandom_range(8, 13);
      s = $sformatf("%s%c", s, (c == 8) ? 8'd32 : 8'(c));
    end
    return s;
  endfunction

  // Comment body with any nonzero byte values, never closed early by star-slash.
  function automatic string comment_text();
    string      s;
    logic [7:0] c;
    logic [7:0] prev;
    s = "/*";
    prev = 8'd0;
    repeat ($urandom_range(0, 8)) begin
      c = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 5) == 0) c = "*";
      if (c == 8'd0) c = 8'd1;
      if (prev == "*" && c == "/") c = "x";
      s = $sformatf("%s%c", s, c);
      prev = c;
    end
    return {s, "*/"};
  endfunction

  // Well-formed program text built from random tokens. Words that follow
  // each other are kept apart; symbols often touch their neighbors so that
  // one byte closes a token and makes one of its own.
  task automatic push_random_text(int beats);
    string tok;
    string prev;
    bit    is_word;
    bit    prev_word;
    int    k;
    prev = " ";
    prev_word = 1'b0;
    while (text_q.size() < beats) begin
      k = $urandom_range(0, 9);
      is_word = k <= 5;
      tok = "";
      case (k)
        0, 1, 2: begin
          tok = rand_alnum(1'b1);
          repeat ($urandom_range(0, 10)) tok = {tok, rand_alnum(1'b0)};
        end
        3: tok = reserved[$urandom_range(0, 11)];
        4, 5: repeat ($urandom_range(1, 5)) tok = $sformatf("%s%c", tok,
                                                            8'("0" + $urandom_range(0, 9)));
        6, 7, 8: tok = symbols[$urandom_range(0, 16)];
        default: tok = comment_text();
      endcase
      if ($urandom_range(0, 19) == 0) push_eot();
      else if ((prev_word && is_word) || (prev[prev.len()-1] == "/" && tok[0] == "*") ||
               $urandom_range(0, 1) == 0)
        push_text(blank_run());
      push_text(tok);
      prev = tok;
      prev_word = is_word;
    end
  endtask

  // One error condition per run, since the scanner halts until reset.
  task automatic push_error_tail();
    logic [7:0] c;
    src_beat_t  b;
    err_kind = $urandom_range(0, 4);
    case (err_kind)
      0: push_text(" 123456");
      1: push_text(" abcdefghijkl");
      2: push_text(" :x");
      3: begin
        push_text(" :");
        push_eot();
      end
      default: begin
        do c = 8'($urandom_range(0, 255));
        while (is_letter(c) || is_digit(c) || is_blank(c) ||
               c inside {"+", "-", "*", "/", "=", "<", ">", ":", "(", ")",
                         ",", ";", "."});
        push_text(" ");
        // Queued directly, since a NUL byte would vanish from a string.
        b.ch = c;
        b.eot = 1'b0;
        text_q.push_back(b);
      end
    endcase
    // Bytes after the error must be dropped without a result.
    push_text("x+1;");
    push_eot();
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset and timeout
  // --------------------------------------------------------------------------
  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 400000) begin
      $display("%0t timeout with %0d bytes unsent and %0d tokens pending",
               $time, text_q.size(), token_q.size());
      $display("testbench: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver: accepts at the rising edge, presents the next beat at the falling
  // edge. The idle rates change with the number of beats sent: sender at 30%
  // and receiver at 60% first, then swapped, then no idling at all.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    took = 1'b0;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_beat(text_q[0].ch, text_q[0].eot);
      text_q.pop_front();
      beats_sent++;
      took = 1'b1;
    end
  end

  always @(negedge clk) begin
    int send_idle;
    send_idle = (beats_sent < 300) ? 30 : (beats_sent < 600) ? 60 : 0;
    if (rst_n && (!in_ch.valid || took)) begin
      if (text_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        in_ch.valid       = 1'b1;
        in_ch.character   = text_q[0].ch;
        in_ch.end_of_text = text_q[0].eot;
      end else begin
        in_ch.valid = 1'b0;
      end
    end
  end

  // Receiver. Once, in the phase without idling, it refuses tokens for a long
  // stretch while bytes keep coming so that the internal queue backs up.
  always @(negedge clk) begin
    int recv_idle;
    recv_idle = (beats_sent < 300) ? 60 : (beats_sent < 600) ? 30 : 0;
    if (!rst_n) out_ch.ready = 1'b0;
    else if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else if (!hold_done && beats_sent >= 650) begin
      out_ch.ready = 1'b0;
      hold_left = 200;
      hold_done = 1'b1;
    end else begin
      out_ch.ready = ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every token beat is checked against the oldest prediction.
  // --------------------------------------------------------------------------
  task automatic check_field(string fname, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t token %0d %s mismatch: expected %0h, actual %0h",
               $time, toks_seen, fname, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    pl0s_pkg::tok_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (token_q.size() == 0) begin
        $display("%0t unexpected token: expected none, actual code %0d status %0d",
                 $time, out_ch.token_code, out_ch.status);
        fail_cnt++;
      end else begin
        want = token_q.pop_front();
        check_field("token_code", want.token_code, out_ch.token_code);
        check_field("number_value", want.number_value, out_ch.number_value);
        check_field("name_first", want.name_first, out_ch.name_first);
        check_field("name_rest", want.name_rest, out_ch.name_rest);
        check_field("name_length", want.name_length, out_ch.name_length);
        check_field("status", want.status, out_ch.status);
        check_field("run_last", want.run_last, out_ch.run_last);
      end
      toks_seen++;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_ch.valid = 1'b0;
    in_ch.character = 8'd0;
    in_ch.end_of_text = 1'b0;
    out_ch.ready = 1'b0;
    mode = SM_IDLE;
    char_cnt = 0;
    num_acc = '0;

    // Directed text: longest name, largest and smallest numbers, two-character
    // symbols, slash lookahead, a comment that the opener's star cannot close,
    // and end markers that flush pending <, > and / tokens and cut an open comment.
    push_text("abcdefghijk:=99999;0<>a/b/*/ */<=>=");
    push_eot();
    push_text("<");
    push_eot();
    push_text(">");
    push_eot();
    push_text("/");
    push_eot();
    push_text("/* open");
    push_eot();
    push_eot();
    push_random_text(800);
    push_error_tail();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (text_q.size() == 0);
    wait (token_q.size() == 0);
    repeat (20) @(posedge clk);

    $display("Sent %0d source bytes and checked %0d tokens, with a long output stall",
             beats_sent, toks_seen);
    $display("and a final halting error of kind %0d.", err_kind);
    if (fail_cnt == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
